// ===== src/checksum_frame_parser_top_macros.svh =====
// assertion macros for the checksum frame parser
// no dependencies; included by files that carry concurrent assertions
`ifndef CHECKSUM_FRAME_PARSER_TOP_MACROS_SVH
`define CHECKSUM_FRAME_PARSER_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define CFP_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// plain invariant checked on every clock edge outside reset
`define CFP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== src/cfp_pkg.sv =====
// shared constants and types for the checksum frame parser
// no dependencies
package cfp_pkg;

   localparam logic [7:0] START_BYTE = 8'h53;
   localparam logic [7:0] CMD_POLL   = 8'h60;
   localparam logic [7:0] CMD_BUZZ   = 8'h6A;

   localparam int STORE_DEPTH   = 11;
   localparam int STORE_IDX_W   = 4;
   localparam int MIN_HELD      = 6;
   localparam int MIN_HELD_BUZZ = 11;

   localparam logic KIND_POLL = 1'b0;
   localparam logic KIND_BUZZ = 1'b1;

   typedef struct packed {
      logic       command_kind;
      logic [7:0] address;
      logic [7:0] sequence_res;
      logic [7:0] reader;
      logic [7:0] tone;
      logic [7:0] on_time;
      logic [7:0] off_time;
      logic [7:0] repeat_count;
   } rsp_type;

endpackage

// ===== src/checksum_frame_parser_top.sv =====
// a closing byte's result is registered into the head slot, or into the skid slot while the head waits
// throughput: one byte per cycle while the skid slot is free, set by the running sum and compare
// a two-entry result buffer lets bytes keep flowing while one result waits
// reset: synchronous, active high; clears hunting state, count, sum and result buffer
// frame byte store is not cleared; a result only reads bytes of the current frame
// depends on cfp_pkg and checksum_frame_parser_top_macros.svh
`include "checksum_frame_parser_top_macros.svh"

module checksum_frame_parser_top
   import cfp_pkg::*;
#(
   parameter int MAX_FRAME = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_command_kind,
   output logic [7:0] rsp_address,
   output logic [7:0] rsp_sequence_res,
   output logic [7:0] rsp_reader,
   output logic [7:0] rsp_tone,
   output logic [7:0] rsp_on_time,
   output logic [7:0] rsp_off_time,
   output logic [7:0] rsp_repeat_count
);

   // count must hold MAX_FRAME itself
   localparam int CW = $clog2(MAX_FRAME + 1);

   // frame state
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    field_ff [STORE_DEPTH];

   // result buffer: head drives the ports, skid catches a result while head waits
   logic    head_valid_ff, head_valid_in;
   rsp_type head_ff, head_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   logic       accept;
   logic       pop;
   logic       store_wr;
   logic [7:0] expect_byte;
   logic       overflow;
   logic       match;
   logic       close;
   logic       emit;
   rsp_type    result;

   assign accept    = req_valid && req_ready;
   assign pop       = head_valid_ff && rsp_ready;
   // only a full skid slot holds off the input side
   assign req_ready = !skid_valid_ff;

   // two's complement of the sum of the bytes held so far
   assign expect_byte = 8'h00 - sum_ff;
   assign overflow    = count_ff >= CW'(MAX_FRAME);
   // closing byte needs at least six bytes before it, eleven for a buzzer frame
   assign match = (req_rx_byte == expect_byte) && (count_ff >= CW'(MIN_HELD));
   assign close = in_frame_ff && !overflow && match &&
                  !((field_ff[5] == CMD_BUZZ) && (count_ff < CW'(MIN_HELD_BUZZ)));
   // unknown commands close silently
   assign emit  = accept && close &&
                  ((field_ff[5] == CMD_POLL) || (field_ff[5] == CMD_BUZZ));
   // first eleven bytes land in the store, later ones are only counted
   assign store_wr = accept && (in_frame_ff ? (!overflow && (count_ff < CW'(STORE_DEPTH)))
                                            : (req_rx_byte == START_BYTE));

   always_comb begin
      result              = '0;
      result.address      = field_ff[1];
      result.sequence_res = field_ff[4];
      if (field_ff[5] == CMD_BUZZ) begin
         result.command_kind = KIND_BUZZ;
         result.reader       = field_ff[6];
         result.tone         = field_ff[7];
         result.on_time      = field_ff[8];
         result.off_time     = field_ff[9];
         result.repeat_count = field_ff[10];
      end else begin
         result.command_kind = KIND_POLL;
      end
   end

   // frame state next value
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            // hunting: only the start byte opens a frame
            if (req_rx_byte == START_BYTE) begin
               in_frame_in = 1'b1;
               count_in    = CW'(1);
               sum_in      = START_BYTE;
            end
         end else if (overflow || close) begin
            // drop an overlong frame, or finish a good one; hunt again
            in_frame_in = 1'b0;
            count_in    = '0;
            sum_in      = 8'h00;
         end else begin
            count_in = count_ff + CW'(1);
            sum_in   = sum_ff + req_rx_byte;
         end
      end
   end

   // result buffer next value
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = emit;
            skid_in       = result;
         end else begin
            head_valid_in = emit;
            head_in       = result;
         end
      end else if (emit) begin
         if (head_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end else begin
            head_valid_in = 1'b1;
            head_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= 8'h00;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
      if (store_wr) begin
         // while hunting count is zero, so the start byte goes to entry zero
         field_ff[count_ff[STORE_IDX_W-1:0]] <= req_rx_byte;
      end
   end

   assign rsp_valid        = head_valid_ff;
   assign rsp_command_kind = head_ff.command_kind;
   assign rsp_address      = head_ff.address;
   assign rsp_sequence_res = head_ff.sequence_res;
   assign rsp_reader       = head_ff.reader;
   assign rsp_tone         = head_ff.tone;
   assign rsp_on_time      = head_ff.on_time;
   assign rsp_off_time     = head_ff.off_time;
   assign rsp_repeat_count = head_ff.repeat_count;

   // skid slot is only filled behind a waiting head
   `CFP_ASSERT_IMPL(a_skid_behind_head, clock, reset, skid_valid_ff, head_valid_ff,
      "skid slot holds an item while head is empty")
   // hunting means nothing held
   `CFP_ASSERT_IMPL(a_hunt_empty, clock, reset, !in_frame_ff,
      (count_ff == '0) && (sum_ff == 8'h00), "hunting with bytes still held")
   // held count never passes the frame limit
   `CFP_ASSERT_ALWAYS(a_count_limit, clock, reset, count_ff <= CW'(MAX_FRAME),
      "byte count beyond frame limit")
   // a new result only follows an accepted byte
   `CFP_ASSERT_IMPL(a_result_from_byte, clock, reset, $rose(head_valid_ff),
      $past(accept), "result appeared without an accepted byte")

endmodule

// ===== tb/checksum_frame_parser_top_tb.sv =====
// self-checking testbench for checksum_frame_parser_top
// depends on cfp_pkg and the parser rtl; a local frame predictor sets the expected results
// named tests run in turn: directed frames, early matches, unknown commands, overflow, random
module checksum_frame_parser_top_tb
   import cfp_pkg::*;
();

   localparam int CLOCK_PERIOD = 12;
   localparam int FRAME_LIMIT  = 64;     // MAX_FRAME of the instance
   localparam int ITEM_GOAL    = 1250;   // bytes taken inside frames before random traffic stops
   localparam int TAIL_CYCLES  = 20;     // settle time after the last result
   localparam int CYCLE_LIMIT  = 300000; // watchdog, far beyond the slowest legal run

   typedef logic [7:0] byte_q_type[$];

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_command_kind;
   logic [7:0] rsp_address;
   logic [7:0] rsp_sequence_res;
   logic [7:0] rsp_reader;
   logic [7:0] rsp_tone;
   logic [7:0] rsp_on_time;
   logic [7:0] rsp_off_time;
   logic [7:0] rsp_repeat_count;

   // frame predictor state
   logic       frame_open = 1'b0;
   int         held_count = 0;
   logic [7:0] byte_sum   = 8'h00;
   logic [7:0] frame_head [STORE_DEPTH];

   rsp_type    results_due[$];
   int         error_count = 0;
   int         items_sent  = 0;
   bit         send_quiet  = 1'b0;   // sender idles between items unless set
   bit         recv_quiet  = 1'b0;   // receiver stalls unless set

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   checksum_frame_parser_top #(
      .MAX_FRAME(FRAME_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_command_kind(rsp_command_kind),
      .rsp_address     (rsp_address),
      .rsp_sequence_res(rsp_sequence_res),
      .rsp_reader      (rsp_reader),
      .rsp_tone        (rsp_tone),
      .rsp_on_time     (rsp_on_time),
      .rsp_off_time    (rsp_off_time),
      .rsp_repeat_count(rsp_repeat_count)
   );

   // one received byte through the parser; returns 1 when a frame yields a result
   function automatic bit parse_rx_byte(input logic [7:0] rx, output rsp_type res);
      logic [7:0] want;
      logic [7:0] cmd;
      int         prior;
      res = '0;
      // hunting: only the start byte opens a frame, everything else is dropped
      if (!frame_open) begin
         if (rx == START_BYTE) begin
            frame_open    = 1'b1;
            held_count    = 1;
            byte_sum      = rx;
            frame_head[0] = rx;
         end
         return 1'b0;
      end
      // frame already full: this byte and the frame are discarded, no checksum test
      if (held_count >= FRAME_LIMIT) begin
         frame_open = 1'b0;
         held_count = 0;
         byte_sum   = 8'h00;
         return 1'b0;
      end
      want  = 8'h00 - byte_sum;
      prior = held_count;
      if (held_count < STORE_DEPTH)
         frame_head[held_count] = rx;
      held_count++;
      byte_sum = byte_sum + rx;
      // a checksum match only closes once enough bytes were held before it
      if (rx != want || prior < MIN_HELD)
         return 1'b0;
      cmd = frame_head[5];
      if (cmd == CMD_BUZZ && prior < MIN_HELD_BUZZ)
         return 1'b0;
      frame_open = 1'b0;
      held_count = 0;
      byte_sum   = 8'h00;
      // closed frame with an unknown command gives nothing
      if (cmd != CMD_POLL && cmd != CMD_BUZZ)
         return 1'b0;
      res.command_kind = (cmd == CMD_BUZZ) ? KIND_BUZZ : KIND_POLL;
      res.address      = frame_head[1];
      res.sequence_res = frame_head[4];
      if (cmd == CMD_BUZZ) begin
         res.reader       = frame_head[6];
         res.tone         = frame_head[7];
         res.on_time      = frame_head[8];
         res.off_time     = frame_head[9];
         res.repeat_count = frame_head[10];
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
   endtask

   // entered and left at a falling edge; valid stays high when the next item follows at once
   task automatic send_byte(input logic [7:0] rx);
      int      gap;
      rsp_type res;
      gap = send_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // bytes ignored while hunting do not count toward the goal
      if (frame_open || rx == START_BYTE)
         items_sent++;
      if (parse_rx_byte(rx, res))
         results_due = {results_due, res};
      @(negedge clock);
   endtask

   // drop valid and hold off until every predicted result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due.size() != 0) @(negedge clock);
   endtask

   // frame bytes followed by the checksum byte, or by a wrong one when corrupt is set
   task automatic send_framed(input byte_q_type body, input bit corrupt);
      logic [7:0] sum;
      sum = 8'h00;
      foreach (body[i]) begin
         sum = sum + body[i];
         send_byte(body[i]);
      end
      if (corrupt)
         send_byte(8'h00 - sum + 8'($urandom_range(1, 255)));
      else
         send_byte(8'h00 - sum);
   endtask

   // random frame content; early_at places a checksum match where it cannot close
   // (0 for none), and pad adds bytes that never match before the real checksum
   task automatic send_random_frame(input logic [7:0] cmd, input int pad, input int early_at,
                                    input bit corrupt);
      byte_q_type body;
      logic [7:0] sum;
      logic [7:0] b;
      int         len;
      body = {};
      body = {body, START_BYTE};
      sum = START_BYTE;
      len = ((cmd == CMD_BUZZ) ? MIN_HELD_BUZZ : MIN_HELD) + pad;
      for (int i = 1; i < len; i++) begin
         if (i == 5) begin
            b = cmd;
         end else if (i == early_at) begin
            b = 8'h00 - sum;
         end else begin
            b = 8'($urandom_range(0, 255));
            // keep an accidental match from closing the frame early
            if (i >= MIN_HELD && !(cmd == CMD_BUZZ && i < MIN_HELD_BUZZ) && b == 8'h00 - sum)
               b = b + 8'h01;
         end
         body = {body, b};
         sum = sum + b;
      end
      send_framed(body, corrupt);
   endtask

   function automatic logic [7:0] unknown_command();
      logic [7:0] cmd;
      cmd = 8'($urandom_range(0, 255));
      while (cmd == CMD_POLL || cmd == CMD_BUZZ)
         cmd = 8'($urandom_range(0, 255));
      return cmd;
   endfunction

   // after a broken frame: feed bytes, often the matching one, until the parser hunts again
   task automatic resync_to_hunting();
      bit can_close;
      while (frame_open) begin
         can_close = held_count >= MIN_HELD &&
                     !(frame_head[5] == CMD_BUZZ && held_count < MIN_HELD_BUZZ);
         if (can_close && $urandom_range(0, 3) != 0)
            send_byte(8'h00 - byte_sum);
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // extremes of address, sequence, reader and tone, start byte as data, noise while hunting, both commands
   task automatic test_directed_frames();
      byte_q_type body;
      send_byte(8'h00);
      send_byte(8'hFF);
      body = {START_BYTE, 8'hFF, START_BYTE, 8'h00, 8'h00, CMD_POLL};
      send_framed(body, 1'b0);
      body = {START_BYTE, 8'h00, 8'h55, 8'hAA, 8'hFF, CMD_BUZZ,
              8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
      send_framed(body, 1'b0);
      drain_results();
   endtask

   // matches that come with too few bytes, in poll frames and short buzzer frames
   task automatic test_early_matches();
      for (int n = 0; n < 16; n++) begin
         if (n % 2 == 0)
            send_random_frame(CMD_POLL, $urandom_range(0, 3), $urandom_range(1, 4), 1'b0);
         else
            send_random_frame(CMD_BUZZ, $urandom_range(0, 3), $urandom_range(6, 10), 1'b0);
      end
      drain_results();
   endtask

   // valid closes with an unknown command yield nothing; a poll frame follows each
   task automatic test_unknown_commands();
      for (int n = 0; n < 8; n++) begin
         send_random_frame(unknown_command(), $urandom_range(0, 4), 0, 1'b0);
         send_random_frame(CMD_POLL, 0, 0, 1'b0);
      end
      drain_results();
   endtask

   // fill a frame to the limit; the next byte, even a matching one, drops the frame
   task automatic test_overflow();
      logic [7:0] cmd;
      logic [7:0] b;
      for (int n = 0; n < 3; n++) begin
         cmd = (n == 0) ? CMD_POLL : (n == 1) ? CMD_BUZZ : unknown_command();
         send_byte(START_BYTE);
         while (held_count < FRAME_LIMIT) begin
            if (held_count == 5) begin
               b = cmd;
            end else begin
               b = 8'($urandom_range(0, 255));
               if (held_count >= MIN_HELD && b == 8'h00 - byte_sum)
                  b = b + 8'h01;
            end
            send_byte(b);
         end
         send_byte(8'h00 - byte_sum);
         // parser must be hunting again
         send_random_frame(CMD_POLL, 0, 0, 1'b0);
      end
      drain_results();
   endtask

   // mostly well-formed frames with random content, plus broken frames and line noise
   task automatic test_random_traffic();
      int pick;
      int pad;
      while (items_sent < ITEM_GOAL) begin
         // stretches with no idling on either side
         send_quiet = ($urandom_range(0, 5) == 0);
         recv_quiet = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
         if (pick < 40) begin
            send_random_frame(CMD_POLL, pad, 0, 1'b0);
         end else if (pick < 70) begin
            send_random_frame(CMD_BUZZ, pad, 0, 1'b0);
         end else if (pick < 77) begin
            send_random_frame(unknown_command(), pad, 0, 1'b0);
         end else if (pick < 85) begin
            if (pick % 2 == 0)
               send_random_frame(CMD_POLL, pad, $urandom_range(1, 4), 1'b0);
            else
               send_random_frame(CMD_BUZZ, pad, $urandom_range(6, 10), 1'b0);
         end else if (pick < 92) begin
            send_random_frame(($urandom_range(0, 1) == 0) ? CMD_POLL : CMD_BUZZ, pad, 0, 1'b1);
            resync_to_hunting();
         end else begin
            // noise between frames; a stray start byte opens a frame that is then resolved
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            resync_to_hunting();
         end
         if ($urandom_range(0, 39) == 0)
            drain_results();
      end
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      drain_results();
   endtask

   // result side: random stall before each item
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = recv_quiet ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // every accepted result is compared with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result, address %02h", rsp_address));
         end else begin
            want = results_due.pop_front();
            check_field("command_kind", {7'd0, rsp_command_kind}, {7'd0, want.command_kind});
            check_field("address", rsp_address, want.address);
            check_field("sequence_res", rsp_sequence_res, want.sequence_res);
            check_field("reader", rsp_reader, want.reader);
            check_field("tone", rsp_tone, want.tone);
            check_field("on_time", rsp_on_time, want.on_time);
            check_field("off_time", rsp_off_time, want.off_time);
            check_field("repeat_count", rsp_repeat_count, want.repeat_count);
         end
      end
   end

   // watchdog
   initial begin
      #(CYCLE_LIMIT * CLOCK_PERIOD);
      $display("checksum_frame_parser_top test failed");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frames();
      test_early_matches();
      test_unknown_commands();
      test_overflow();
      test_random_traffic();

      // let any stray result show up before the verdict
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("checksum_frame_parser_top test passed");
      else
         $display("checksum_frame_parser_top test failed");
      $finish;
   end

endmodule
